/* rtl/core/stde_pkg.sv */
// Shared types and constants for the spike train edit distance block.
package stde_pkg;

    // Fixed field widths of the stream words
    localparam int SPIKE_W = 16;
    localparam int CPU_W   = 16;
    localparam int DIST_W  = 20;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CPU_W-1:0]  CPU_RESET = 16'd4096;
    localparam logic [DIST_W-1:0] DIST_MAX  = 20'hFFFFF;

    // Item kinds carried in tuser; code 3 is ignored
    typedef enum logic [1:0] {
        FUNC_APPEND_ONE = 2'd0,
        FUNC_APPEND_TWO = 2'd1,
        FUNC_COMPUTE    = 2'd2
    } stde_func_t;

    // Engine status toward the top level
    typedef struct packed {
        logic busy;
        logic done;
    } stde_status_t;

endpackage

/* rtl/core/stde_train_mem.sv */
// Spike time storage for one train: one write port, one registered read port.
module stde_train_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int WIDTH  = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/stde_engine.sv */
// Cost table engine: walks the table row by row, one cell per cycle within a row, in a row memory.
module stde_engine
    import stde_pkg::*;
#(
    parameter int MAX_SPIKES = 64,
    parameter int TIME_W     = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  logic [$clog2(MAX_SPIKES+1)-1:0]          n_one,
    input  logic [$clog2(MAX_SPIKES+1)-1:0]          n_two,
    input  logic [CPU_W-1:0]                         cost_per_unit,
    output logic [((MAX_SPIKES > 1) ? $clog2(MAX_SPIKES) : 1)-1:0] addr_one,
    output logic [((MAX_SPIKES > 1) ? $clog2(MAX_SPIKES) : 1)-1:0] addr_two,
    input  logic [TIME_W-1:0]                        t_one,
    input  logic [TIME_W-1:0]                        t_two,
    output logic [FRAC_BITS+$clog2(MAX_SPIKES+1):0]  result,
    output stde_status_t                             status
);

    localparam int CNT_W  = $clog2(MAX_SPIKES + 1);
    localparam int ADDR_W = (MAX_SPIKES > 1) ? $clog2(MAX_SPIKES) : 1;
    localparam int COST_W = FRAC_BITS + CNT_W + 1;
    localparam int PW     = TIME_W + CPU_W;
    localparam int SW     = FRAC_BITS + 2;
    localparam logic [COST_W-1:0] ONE = COST_W'(1) << FRAC_BITS;
    localparam logic [SW-1:0]     CAP = SW'(2) << FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ROW,
        ST_DRAIN1,
        ST_DRAIN2
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  i_reg, j_reg, n1_reg, n2_reg;
    logic [TIME_W-1:0] t1_reg;
    logic              done_reg;
    logic [COST_W-1:0] result_reg;

    // pipeline
    logic              s1_valid_reg, s2_valid_reg;
    logic [CNT_W-1:0]  s1_j_reg, s2_j_reg;
    logic              s2_first_reg;
    logic [PW-1:0]     s2_prod_reg;
    logic [COST_W-1:0] s2_up_reg;
    logic [COST_W-1:0] left_reg, diag_reg;

    logic [COST_W-1:0] row_mem [MAX_SPIKES+1];
    logic [COST_W-1:0] row_rd_reg;

    logic [CNT_W-1:0]  j_less;
    logic              first_row;
    logic [TIME_W-1:0] diff;
    logic [PW-1:0]     prod;
    logic [COST_W-1:0] up_v;
    logic [SW-1:0]     shift_c;
    logic [COST_W-1:0] diag_v, left_v;
    logic [COST_W-1:0] cand_up, cand_left, cand_diag, best_a, best;

    // read addresses for the train memories
    assign j_less = j_reg - CNT_W'(1);

    always_comb
    begin
        addr_one = '0;
        addr_two = j_less[ADDR_W-1:0];
        unique case (state_reg)
            ST_IDLE:   addr_one = '0;
            ST_DRAIN2: addr_one = i_reg[ADDR_W-1:0];
            default:   addr_one = '0;
        endcase
    end

    // stage 1: time difference and shift cost product
    assign first_row = (i_reg == CNT_W'(1));
    assign diff = (t1_reg >= t_two) ? (t1_reg - t_two) : (t_two - t1_reg);
    assign prod = PW'(diff) * PW'(cost_per_unit);
    assign up_v = first_row ? (COST_W'(s1_j_reg) << FRAC_BITS) : row_rd_reg;

    // stage 2: cell minimum
    assign shift_c   = (s2_prod_reg > PW'(CAP)) ? CAP : SW'(s2_prod_reg);
    assign diag_v    = s2_first_reg ? (COST_W'(i_reg - CNT_W'(1)) << FRAC_BITS) : diag_reg;
    assign left_v    = s2_first_reg ? (COST_W'(i_reg) << FRAC_BITS) : left_reg;
    assign cand_up   = s2_up_reg + ONE;
    assign cand_left = left_v + ONE;
    assign cand_diag = diag_v + COST_W'(shift_c);
    assign best_a    = (cand_left < cand_up) ? cand_left : cand_up;
    assign best      = (cand_diag < best_a) ? cand_diag : best_a;

    // sequencer: state, row and column counters, result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            n1_reg     <= '0;
            n2_reg     <= '0;
            t1_reg     <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        n1_reg    <= n_one;
                        n2_reg    <= n_two;
                        i_reg     <= CNT_W'(1);
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH:
                begin
                    t1_reg    <= t_one;
                    j_reg     <= CNT_W'(1);
                    state_reg <= ST_ROW;
                end
                ST_ROW:
                begin
                    if (j_reg == n2_reg)
                    begin
                        state_reg <= ST_DRAIN1;
                    end
                    else
                    begin
                        j_reg <= j_reg + CNT_W'(1);
                    end
                end
                ST_DRAIN1:
                begin
                    state_reg <= ST_DRAIN2;
                end
                ST_DRAIN2:
                begin
                    // last cell of the row is in stage 2 now
                    if (i_reg == n1_reg)
                    begin
                        result_reg <= best;
                        done_reg   <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CNT_W'(1);
                        state_reg <= ST_FETCH;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= (state_reg == ST_ROW);
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // pipeline payload and row memory
    always_ff @(posedge clk)
    begin
        s1_j_reg     <= j_reg;
        s2_j_reg     <= s1_j_reg;
        s2_first_reg <= (s1_j_reg == CNT_W'(1));
        s2_prod_reg  <= prod;
        s2_up_reg    <= up_v;
        row_rd_reg   <= row_mem[j_reg];
        if (s2_valid_reg)
        begin
            row_mem[s2_j_reg] <= best;
            left_reg          <= best;
            diag_reg          <= s2_up_reg;
        end
    end

    assign result      = result_reg;
    assign status.busy = (state_reg != ST_IDLE) || done_reg;
    assign status.done = done_reg;

endmodule

/* rtl/core/spike_train_edit_distance.sv */
// Top level of the spike train edit distance block: stream ports, trains, result register.
//
// Victor-Purpura distance between two spike trains of up to MAX_SPIKES integer
// spike times each. Input words carry the kind in s_tuser (append to train one,
// append to train two, compute) and the spike time in s_tdata. Appends beyond
// capacity are dropped and flagged in the status bit of the next result. A
// compute with either train empty returns its result in the cycle after
// acceptance. Otherwise the engine walks the cost table one cell per cycle
// within a row through a row memory, with a train fetch and a pipeline drain
// per row; no word is accepted while the engine is busy. Both trains and the
// drop flag are cleared by every compute. An output register holds the result,
// so appends are taken while it waits; the next compute waits until it has been
// taken. cost_per_unit is written through cfg_we/cfg_wdata; the user must write
// it only while the block is idle, as the block itself leaves this unchecked.
module spike_train_edit_distance
    import stde_pkg::*;
#(
    parameter int MAX_SPIKES = 64,
    parameter int TIME_BITS  = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] spike_time
    input  logic [1:0]             s_tuser,   // [1:0] func
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [19:0] distance, [23:20] zero
    output logic [0:0]             m_tuser,   // [0] status
    input  logic                   cfg_we,
    input  logic [CPU_W-1:0]       cfg_wdata
);

    localparam int CNT_W  = $clog2(MAX_SPIKES + 1);
    localparam int ADDR_W = (MAX_SPIKES > 1) ? $clog2(MAX_SPIKES) : 1;
    localparam int COST_W = FRAC_BITS + CNT_W + 1;
    localparam int TW     = (TIME_BITS < SPIKE_W) ? TIME_BITS : SPIKE_W;
    localparam int WIDE_W = (COST_W > DIST_W) ? COST_W : DIST_W;

    logic [CPU_W-1:0]  cost_per_unit_reg;
    logic [CNT_W-1:0]  cnt_one_reg, cnt_two_reg;
    logic              overflow_reg;
    logic              pend_status_reg;
    logic              out_valid_reg;
    logic [DIST_W-1:0] out_dist_reg;
    logic              out_status_reg;

    stde_func_t        func;
    logic              s_acc;
    logic              is_compute;
    logic              one_room, two_room;
    logic              we_one, we_two;
    logic              trivial;
    logic              eng_start;
    logic [ADDR_W-1:0] addr_one, addr_two;
    logic [TW-1:0]     t_one, t_two;
    logic [COST_W-1:0] eng_result;
    stde_status_t      eng_status;
    logic [COST_W-1:0] triv_cost;
    logic [WIDE_W-1:0] triv_wide, eng_wide;
    logic [DIST_W-1:0] triv_dist, eng_dist;

    // input handshake; a compute needs the output register free
    assign func       = stde_func_t'(s_tuser);
    assign is_compute = (func == FUNC_COMPUTE);
    assign s_tready   = !eng_status.busy && !(is_compute && out_valid_reg);
    assign s_acc      = s_tvalid && s_tready;

    assign one_room  = (cnt_one_reg < CNT_W'(MAX_SPIKES));
    assign two_room  = (cnt_two_reg < CNT_W'(MAX_SPIKES));
    assign we_one    = s_acc && (func == FUNC_APPEND_ONE) && one_room;
    assign we_two    = s_acc && (func == FUNC_APPEND_TWO) && two_room;
    assign trivial   = (cnt_one_reg == '0) || (cnt_two_reg == '0);
    assign eng_start = s_acc && is_compute && !trivial;

    // distance with an empty train: the other train's length
    assign triv_cost = (COST_W'(cnt_one_reg) + COST_W'(cnt_two_reg)) << FRAC_BITS;
    assign triv_wide = WIDE_W'(triv_cost);
    assign eng_wide  = WIDE_W'(eng_result);
    assign triv_dist = (triv_wide > WIDE_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(triv_wide);
    assign eng_dist  = (eng_wide > WIDE_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(eng_wide);

    stde_train_mem #(
        .DEPTH  (MAX_SPIKES),
        .ADDR_W (ADDR_W),
        .WIDTH  (TW)
    ) u_train_one (
        .clk   (clk),
        .we    (we_one),
        .waddr (cnt_one_reg[ADDR_W-1:0]),
        .wdata (s_tdata[TW-1:0]),
        .raddr (addr_one),
        .rdata (t_one)
    );

    stde_train_mem #(
        .DEPTH  (MAX_SPIKES),
        .ADDR_W (ADDR_W),
        .WIDTH  (TW)
    ) u_train_two (
        .clk   (clk),
        .we    (we_two),
        .waddr (cnt_two_reg[ADDR_W-1:0]),
        .wdata (s_tdata[TW-1:0]),
        .raddr (addr_two),
        .rdata (t_two)
    );

    stde_engine #(
        .MAX_SPIKES (MAX_SPIKES),
        .TIME_W     (TW),
        .FRAC_BITS  (FRAC_BITS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (eng_start),
        .n_one         (cnt_one_reg),
        .n_two         (cnt_two_reg),
        .cost_per_unit (cost_per_unit_reg),
        .addr_one      (addr_one),
        .addr_two      (addr_two),
        .t_one         (t_one),
        .t_two         (t_two),
        .result        (eng_result),
        .status        (eng_status)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_per_unit_reg <= CPU_RESET;
        end
        else if (cfg_we)
        begin
            cost_per_unit_reg <= cfg_wdata;
        end
    end

    // train counts, drop flag and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_one_reg     <= '0;
            cnt_two_reg     <= '0;
            overflow_reg    <= 1'b0;
            pend_status_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_dist_reg    <= '0;
            out_status_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (s_acc)
            begin
                case (func)
                    FUNC_APPEND_ONE:
                    begin
                        if (one_room)
                            cnt_one_reg <= cnt_one_reg + CNT_W'(1);
                        else
                            overflow_reg <= 1'b1;
                    end
                    FUNC_APPEND_TWO:
                    begin
                        if (two_room)
                            cnt_two_reg <= cnt_two_reg + CNT_W'(1);
                        else
                            overflow_reg <= 1'b1;
                    end
                    FUNC_COMPUTE:
                    begin
                        if (trivial)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_dist_reg   <= triv_dist;
                            out_status_reg <= overflow_reg;
                        end
                        pend_status_reg <= overflow_reg;
                        cnt_one_reg     <= '0;
                        cnt_two_reg     <= '0;
                        overflow_reg    <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            // engine result lands in the free output register
            if (eng_status.done)
            begin
                out_valid_reg  <= 1'b1;
                out_dist_reg   <= eng_dist;
                out_status_reg <= pend_status_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-DIST_W){1'b0}}, out_dist_reg};
    assign m_tuser  = out_status_reg;

    // checks
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        eng_status.busy |-> !s_tready)
        else $error("word accepted while the engine is busy");

    a_done_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        eng_status.done |-> !out_valid_reg)
        else $error("engine result while the output register is full");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        eng_start |=> eng_status.busy)
        else $error("engine did not start");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_one_reg <= CNT_W'(MAX_SPIKES)) && (cnt_two_reg <= CNT_W'(MAX_SPIKES)))
        else $error("train count beyond capacity");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for spike_train_edit_distance with scoreboard and stream drivers.
`timescale 1ns / 1ps

module tb;
    import stde_pkg::*;

    localparam int          MAX_SPIKES  = 64;
    localparam logic [31:0] COST_ONE    = 32'd4096;
    localparam logic [31:0] SHIFT_CAP   = 32'd8192;
    localparam logic [1:0]  FUNC_UNUSED = 2'd3;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          NUM_PHASES  = 8;
    localparam int          PHASE_WORDS = 85;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              status;
    } vp_result_t;

    // Predictor of the distance engine plus the queue of expected results
    class vp_scoreboard;
        logic [CPU_W-1:0]   cost_per_unit;
        logic [SPIKE_W-1:0] times_one [MAX_SPIKES];
        logic [SPIKE_W-1:0] times_two [MAX_SPIKES];
        int unsigned        n_one;
        int unsigned        n_two;
        bit                 dropped;
        vp_result_t         expected_q [$];
        int unsigned        errors;
        int unsigned        distances;
        int unsigned        drop_results;

        function new();
            cost_per_unit = CPU_RESET;
            n_one         = 0;
            n_two         = 0;
            dropped       = 1'b0;
            errors        = 0;
            distances     = 0;
            drop_results  = 0;
        endfunction

        function void set_cost(logic [CPU_W-1:0] value);
            cost_per_unit = value;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Edit distance over the stored trains, one table row at a time
        function logic [DIST_W-1:0] edit_distance();
            logic [31:0]        row [0:MAX_SPIKES];
            logic [31:0]        diag;
            logic [31:0]        up;
            logic [31:0]        best;
            logic [31:0]        shift;
            logic [SPIKE_W-1:0] diff;
            for (int j = 0; j <= n_two; j++)
                row[j] = j * COST_ONE;
            for (int i = 1; i <= n_one; i++)
            begin
                diag   = row[0];
                row[0] = i * COST_ONE;
                for (int j = 1; j <= n_two; j++)
                begin
                    up   = row[j];
                    best = up + COST_ONE;
                    if (row[j-1] + COST_ONE < best)
                        best = row[j-1] + COST_ONE;
                    diff = (times_one[i-1] >= times_two[j-1]) ?
                           times_one[i-1] - times_two[j-1] : times_two[j-1] - times_one[i-1];
                    shift = 32'(cost_per_unit) * 32'(diff);
                    if (shift > SHIFT_CAP)
                        shift = SHIFT_CAP;
                    if (diag + shift < best)
                        best = diag + shift;
                    diag   = up;
                    row[j] = best;
                end
            end
            return (row[n_two] > 32'(DIST_MAX)) ? DIST_MAX : row[n_two][DIST_W-1:0];
        endfunction

        // Accepted input word: update trains or queue a distance
        function void note_word(logic [1:0] func, logic [SPIKE_W-1:0] spike_time);
            vp_result_t res;
            if (func == FUNC_APPEND_ONE)
            begin
                if (n_one < MAX_SPIKES)
                    times_one[n_one++] = spike_time;
                else
                    dropped = 1'b1;
            end
            else if (func == FUNC_APPEND_TWO)
            begin
                if (n_two < MAX_SPIKES)
                    times_two[n_two++] = spike_time;
                else
                    dropped = 1'b1;
            end
            else if (func == FUNC_COMPUTE)
            begin
                res.distance = edit_distance();
                res.status   = dropped;
                expected_q.insert(expected_q.size(), res);
                n_one   = 0;
                n_two   = 0;
                dropped = 1'b0;
            end
        endfunction

        // Accepted output word against the oldest expectation
        function void check_result(logic [DIST_W-1:0] distance, logic status);
            vp_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: unexpected result distance=%0h status=%0b",
                             distance, status);
                return;
            end
            exp_res = expected_q.pop_front();
            distances++;
            if (exp_res.status)
                drop_results++;
            if (distance !== exp_res.distance || status !== exp_res.status)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: distance exp=%0h act=%0h status exp=%0b act=%0b",
                             exp_res.distance, distance, exp_res.status, status);
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_we;
    logic [CPU_W-1:0]       cfg_wdata;

    vp_scoreboard sb = new();
    bit           quiet;
    int unsigned  hold_req;
    int unsigned  words_sent;
    int unsigned  cost_writes;
    int unsigned  cycle_count = 0;

    spike_train_edit_distance u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random stalls, quiet stretch, long hold-off on request
    initial
    begin
        int unsigned hold_seen;
        int unsigned hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (quiet)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 16);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[DIST_W-1:0], m_tuser[0]);
    end

    // One input word with random idle cycles ahead of it
    task automatic send_word(input logic [1:0] func, input logic [SPIKE_W-1:0] spike_time);
        while (!quiet && $urandom_range(99) < 16)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= spike_time;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_word(func, spike_time);
        if (func != FUNC_UNUSED)
            words_sent++;
    endtask

    // Fill both trains in random order, then ask for the distance.
    // spread < 0 gives fully random times, otherwise times sit near one base.
    task automatic send_pair(input int n1, input int n2, input int spread);
        int                 left1;
        int                 left2;
        logic [SPIKE_W-1:0] base;
        logic [SPIKE_W-1:0] t;
        left1 = n1;
        left2 = n2;
        base  = SPIKE_W'($urandom);
        while (left1 + left2 > 0)
        begin
            if ($urandom_range(99) < 4)
                send_word(FUNC_UNUSED, SPIKE_W'($urandom));
            t = (spread < 0) ? SPIKE_W'($urandom) : base + SPIKE_W'($urandom_range(spread));
            if (left2 == 0 || (left1 > 0 && $urandom_range(1) == 1))
            begin
                send_word(FUNC_APPEND_ONE, t);
                left1--;
            end
            else
            begin
                send_word(FUNC_APPEND_TWO, t);
                left2--;
            end
        end
        send_word(FUNC_COMPUTE, SPIKE_W'($urandom));
    endtask

    // Register write once the block has drained
    task automatic write_cost(input logic [CPU_W-1:0] value);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_cost(value);
        cost_writes++;
    endtask

    initial
    begin
        int unsigned      pick;
        int unsigned      phase_end;
        logic [CPU_W-1:0] cost;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = FUNC_APPEND_ONE;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        quiet       = 1'b0;
        hold_req    = 0;
        words_sent  = 0;
        cost_writes = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty trains, one-sided trains, time extremes, ignored kind
        send_word(FUNC_COMPUTE, 16'h0000);
        send_word(FUNC_APPEND_ONE, 16'h0000);
        send_word(FUNC_COMPUTE, 16'hFFFF);
        send_word(FUNC_APPEND_TWO, 16'hFFFF);
        send_word(FUNC_COMPUTE, 16'h0000);
        send_word(FUNC_APPEND_ONE, 16'h0000);
        send_word(FUNC_APPEND_TWO, 16'hFFFF);
        send_word(FUNC_COMPUTE, 16'h5A5A);
        send_word(FUNC_APPEND_ONE, 16'd100);
        send_word(FUNC_APPEND_TWO, 16'd100);
        send_word(FUNC_COMPUTE, 16'hA5A5);
        send_word(FUNC_APPEND_ONE, 16'd100);
        send_word(FUNC_APPEND_TWO, 16'd101);
        send_word(FUNC_COMPUTE, 16'h0000);
        send_word(FUNC_UNUSED, 16'hFFFF);
        send_word(FUNC_APPEND_ONE, 16'd5);
        send_word(FUNC_UNUSED, 16'h0000);
        send_word(FUNC_COMPUTE, 16'h0000);
        send_word(FUNC_APPEND_ONE, 16'd7);
        send_word(FUNC_APPEND_ONE, 16'd9);
        send_word(FUNC_APPEND_TWO, 16'd8);
        send_word(FUNC_COMPUTE, 16'h0000);
        send_word(FUNC_COMPUTE, 16'h0000);

        // Full trains and overflow on either side
        send_pair(MAX_SPIKES, MAX_SPIKES, 3);
        send_pair(MAX_SPIKES + 3, 2, 2);
        send_pair(1, MAX_SPIKES + 2, -1);

        // Random phases, each under its own shift cost
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:       cost = 16'd0;
                1:       cost = 16'hFFFF;
                2:       cost = 16'd1;
                3:       cost = CPU_RESET;
                4:       cost = 16'd300;
                5:       cost = 16'd2048;
                default: cost = CPU_W'($urandom);
            endcase
            write_cost(cost);
            quiet = (phase == 1);
            if (phase == 3)
                hold_req++;
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end)
            begin
                pick = $urandom_range(99);
                if (pick < 62)
                    send_pair($urandom_range(8), $urandom_range(8), 3);
                else if (pick < 72)
                    send_pair($urandom_range(20), $urandom_range(20), -1);
                else if (pick < 82)
                    send_pair($urandom_range(12), $urandom_range(12), 40);
                else if (pick < 84)
                    send_pair($urandom_range(MAX_SPIKES, 50), $urandom_range(MAX_SPIKES, 50), 4);
                else if (pick < 87)
                begin
                    if ($urandom_range(1) == 1)
                        send_pair($urandom_range(MAX_SPIKES + 6, MAX_SPIKES + 1),
                                  $urandom_range(5), 2);
                    else
                        send_pair($urandom_range(5),
                                  $urandom_range(MAX_SPIKES + 6, MAX_SPIKES + 1), 2);
                end
                else if (pick < 93)
                begin
                    if ($urandom_range(1) == 1)
                        send_pair(0, $urandom_range(10), -1);
                    else
                        send_pair($urandom_range(10), 0, -1);
                end
                else
                begin
                    // back-to-back computes with noise words between them
                    repeat ($urandom_range(3, 1))
                    begin
                        if ($urandom_range(1) == 1)
                            send_word(FUNC_UNUSED, SPIKE_W'($urandom));
                        send_word(FUNC_COMPUTE, SPIKE_W'($urandom));
                    end
                end
            end
        end
        quiet = 1'b0;

        // Drain
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d words, %0d distances (%0d with dropped spikes), %0d cost writes",
                 words_sent, sb.distances, sb.drop_results, cost_writes);
        $display("mismatches: %0d, results left over: %0d", sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
